### hw/rtl/fps_pkg.sv
// fps_pkg: shared types, widths and constants of the fader position servo.
// Used by fps_div, fps_cfg, fps_ctrl and fader_position_servo_core.
// No dependencies.
package fps_pkg;

    // Control loop rate; integral and rate scaling follow from it.
    localparam longint LOOP_RATE_HZ = 2000;

    localparam longint Q15_ONE  = 32768;
    localparam longint GAIN_MAX = 65535;
    localparam longint OUT_LIM  = 100 * 524288;          // +-100.0 in 2^-19 units
    localparam longint ILIM     = 50 * Q15_ONE * LOOP_RATE_HZ;
    localparam longint RATE_MAX = Q15_ONE * LOOP_RATE_HZ;

    // Field widths
    localparam int SAMPLE_W = 12;
    localparam int POS_W    = 16;
    localparam int GAIN_W   = 16;
    localparam int DB_W     = 15;
    localparam int MD_W     = 8;
    localparam int DRIVE_W  = 9;
    localparam int DUTY_W   = 8;
    localparam int ERR_W    = POS_W + 1;

    // Datapath widths
    localparam int EI_W      = $clog2(ILIM + Q15_ONE + 1) + 1;
    localparam int FR_W      = $clog2(RATE_MAX + 1) + 1;
    localparam int ACC_MAG_W = $clog2(10 * RATE_MAX + 6);
    localparam int ACC_W     = ACC_MAG_W + 1;
    localparam int IP_MAG_W  = $clog2(GAIN_MAX * ILIM + 1);
    localparam int IT_W      = $clog2(GAIN_MAX * ILIM / LOOP_RATE_HZ + 1) + 1;
    localparam int DP_W      = $clog2(GAIN_MAX * RATE_MAX + 1) + 1;
    localparam int HZ_W      = $clog2(LOOP_RATE_HZ + 1);
    localparam int MB_W0     = (EI_W > FR_W) ? EI_W : FR_W;
    localparam int MB_W      = (MB_W0 > ERR_W) ? MB_W0 : ERR_W;
    localparam int PROD_W    = GAIN_W + 1 + MB_W;
    localparam int SUM_W     = ((IT_W > DP_W) ? IT_W : DP_W) + 2;
    localparam int CL_W      = $clog2(OUT_LIM + 1) + 1;
    localparam int SC_W      = CL_W + 9;
    localparam int OUT_SHIFT = 19;

    // Divider: two quotient bits per cycle
    localparam int DVS_W      = (SAMPLE_W > HZ_W) ? SAMPLE_W : HZ_W;
    localparam int NORM_W     = SAMPLE_W + 15;
    localparam int NORM_PAIRS = (NORM_W + 1) / 2;
    localparam int D10_PAIRS  = (ACC_MAG_W + 1) / 2;
    localparam int DHZ_PAIRS  = (IP_MAG_W + 1) / 2;
    localparam int MAX_PAIRS0 = (NORM_PAIRS > D10_PAIRS) ? NORM_PAIRS : D10_PAIRS;
    localparam int MAX_PAIRS  = (MAX_PAIRS0 > DHZ_PAIRS) ? MAX_PAIRS0 : DHZ_PAIRS;
    localparam int DIV_DW     = 2 * MAX_PAIRS;
    localparam int PAIR_CW    = $clog2(MAX_PAIRS + 1);
    localparam int NORM_SH    = DIV_DW - 2 * NORM_PAIRS;
    localparam int D10_SH     = DIV_DW - 2 * D10_PAIRS;
    localparam int DHZ_SH     = DIV_DW - 2 * DHZ_PAIRS;

    localparam logic [POS_W-1:0] POS_ONE  = POS_W'(Q15_ONE);
    localparam logic [POS_W-1:0] POS_HALF = POS_W'(Q15_ONE / 2);

    // APB register file
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        REG_POT_MIN   = 3'd0,
        REG_POT_MAX   = 3'd1,
        REG_GAIN_P    = 3'd2,
        REG_GAIN_I    = 3'd3,
        REG_GAIN_D    = 3'd4,
        REG_DEADBAND  = 3'd5,
        REG_MIN_DRIVE = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [SAMPLE_W-1:0] pot_min;
        logic [SAMPLE_W-1:0] pot_max;
        logic [GAIN_W-1:0]   gain_p;
        logic [GAIN_W-1:0]   gain_i;
        logic [GAIN_W-1:0]   gain_d;
        logic [DB_W-1:0]     deadband;
        logic [MD_W-1:0]     min_drive;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        pot_min:   12'd200,
        pot_max:   12'd3900,
        gain_p:    16'd12800,
        gain_i:    16'd0,
        gain_d:    16'd0,
        deadband:  15'd492,
        min_drive: 8'd60
    };

    typedef struct packed {
        logic [SAMPLE_W-1:0] pot_sample;
        logic [POS_W-1:0]    target_position;
    } t_in;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic [DUTY_W-1:0]         up_duty;
        logic [DUTY_W-1:0]         down_duty;
        logic [POS_W-1:0]          position;
        logic                      settled;
    } t_out;

    typedef struct packed {
        logic                start;
        logic [DIV_DW-1:0]   dividend;   // left aligned
        logic [DVS_W-1:0]    divisor;
        logic [PAIR_CW-1:0]  pairs;      // quotient bit pairs to produce
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_DW-1:0] quotient;
    } t_div_rsp;

endpackage

### hw/rtl/fader_position_servo_core.sv
// fader_position_servo_core: top level of the motor fader position servo.
// Depends on fps_pkg, fps_cfg, fps_div and fps_ctrl.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data): one transaction is
//   one control tick carrying the averaged pot sample and the target position.
//   Output channel (o_out_valid / i_out_stall / o_out_data): one transaction
//   per tick with signed drive, up/down PWM duties, normalized position and
//   the settled flag.
//   APB port: calibration ends, PID gains, deadband and minimum drive. Write
//   only while no tick is in flight.
// Timing:
//   One tick at a time. A tick that lands in the deadband goes from the error
//   step straight to the result; otherwise it runs the full sequence. The shared
//   two-bit-per-cycle divider runs up to three times per tick: normalization, the
//   derivative filter's divide by ten, and the integral's divide by the loop
//   rate. o_in_stall is high from acceptance until the result is handed to
//   the output register.
// Reset: config registers take their defaults, position goes to half travel,
//   integral, rate filter and previous position clear, output empties.
// Output stall: the result sits in the output register; a next tick may be
//   accepted and run, and waits at its end until the register frees up.
module fader_position_servo_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // tick input
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  fps_pkg::t_in                i_in_data,
    // result output
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output fps_pkg::t_out               o_out_data,
    // APB config
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fps_pkg::ADDR_W-1:0]  paddr,
    input  logic [fps_pkg::DATA_W-1:0]  pwdata,
    output logic [fps_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    fps_pkg::t_cfg     w_cfg;
    fps_pkg::t_div_req w_div_req;
    fps_pkg::t_div_rsp w_div_rsp;
    fps_pkg::t_out     w_res;
    logic              w_ready;
    logic              w_res_valid;
    logic              w_res_ready;

    logic              r_out_valid;
    fps_pkg::t_out     r_out_data;

    fps_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    fps_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    fps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in_data),
        .o_ready     (w_ready),
        .i_cfg       (w_cfg),
        .o_div_req   (w_div_req),
        .i_div_rsp   (w_div_rsp),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res)
    );

    // sequencer busy -> stall the input side
    assign o_in_stall = !w_ready;

    // output register: free when empty or being drained this cycle
    assign w_res_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_out_valid <= 1'b1;
            r_out_data  <= w_res;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

### hw/rtl/fps_div.sv
// fps_div: shared iterative unsigned divider, restoring, two bits per cycle.
// Depends on fps_pkg.
module fps_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fps_pkg::t_div_req i_req,
    output fps_pkg::t_div_rsp o_rsp
);

    logic                        r_busy;
    logic                        r_done;
    logic [fps_pkg::PAIR_CW-1:0] r_cnt;
    logic [fps_pkg::DVS_W-1:0]   r_rem;
    logic [fps_pkg::DVS_W-1:0]   r_dvs;
    logic [fps_pkg::DIV_DW-1:0]  r_quo;   // dividend shifts out, quotient shifts in

    logic [fps_pkg::DVS_W:0]     w_t0;
    logic [fps_pkg::DVS_W:0]     w_t1;
    logic [fps_pkg::DVS_W-1:0]   w_rem0;
    logic [fps_pkg::DVS_W-1:0]   w_rem1;
    logic                        w_q0;
    logic                        w_q1;

    always_comb begin
        w_t0   = {r_rem, r_quo[fps_pkg::DIV_DW-1]};
        w_q0   = (w_t0 >= {1'b0, r_dvs});
        w_rem0 = w_q0 ? fps_pkg::DVS_W'(w_t0 - {1'b0, r_dvs}) : w_t0[fps_pkg::DVS_W-1:0];
        w_t1   = {w_rem0, r_quo[fps_pkg::DIV_DW-2]};
        w_q1   = (w_t1 >= {1'b0, r_dvs});
        w_rem1 = w_q1 ? fps_pkg::DVS_W'(w_t1 - {1'b0, r_dvs}) : w_t1[fps_pkg::DVS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.pairs;
                r_rem  <= '0;
                r_dvs  <= i_req.divisor;
                r_quo  <= i_req.dividend;
            end else if (r_busy) begin
                r_rem <= w_rem1;
                r_quo <= {r_quo[fps_pkg::DIV_DW-3:0], w_q0, w_q1};
                r_cnt <= r_cnt - fps_pkg::PAIR_CW'(1);
                if (r_cnt == fps_pkg::PAIR_CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

### hw/rtl/fps_cfg.sv
// fps_cfg: APB register file for calibration, gains, deadband and minimum drive.
// Depends on fps_pkg.
module fps_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fps_pkg::ADDR_W-1:0]  paddr,
    input  logic [fps_pkg::DATA_W-1:0]  pwdata,
    output logic [fps_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output fps_pkg::t_cfg               o_cfg
);

    fps_pkg::t_cfg r_cfg;
    logic [2:0]    w_idx;
    logic          w_wr;

    assign w_idx  = paddr[4:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= fps_pkg::CFG_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                fps_pkg::REG_POT_MIN:   r_cfg.pot_min   <= pwdata[fps_pkg::SAMPLE_W-1:0];
                fps_pkg::REG_POT_MAX:   r_cfg.pot_max   <= pwdata[fps_pkg::SAMPLE_W-1:0];
                fps_pkg::REG_GAIN_P:    r_cfg.gain_p    <= pwdata[fps_pkg::GAIN_W-1:0];
                fps_pkg::REG_GAIN_I:    r_cfg.gain_i    <= pwdata[fps_pkg::GAIN_W-1:0];
                fps_pkg::REG_GAIN_D:    r_cfg.gain_d    <= pwdata[fps_pkg::GAIN_W-1:0];
                fps_pkg::REG_DEADBAND:  r_cfg.deadband  <= pwdata[fps_pkg::DB_W-1:0];
                fps_pkg::REG_MIN_DRIVE: r_cfg.min_drive <= pwdata[fps_pkg::MD_W-1:0];
                default: ;                      // unmapped: ignored
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            fps_pkg::REG_POT_MIN:   prdata = fps_pkg::DATA_W'(r_cfg.pot_min);
            fps_pkg::REG_POT_MAX:   prdata = fps_pkg::DATA_W'(r_cfg.pot_max);
            fps_pkg::REG_GAIN_P:    prdata = fps_pkg::DATA_W'(r_cfg.gain_p);
            fps_pkg::REG_GAIN_I:    prdata = fps_pkg::DATA_W'(r_cfg.gain_i);
            fps_pkg::REG_GAIN_D:    prdata = fps_pkg::DATA_W'(r_cfg.gain_d);
            fps_pkg::REG_DEADBAND:  prdata = fps_pkg::DATA_W'(r_cfg.deadband);
            fps_pkg::REG_MIN_DRIVE: prdata = fps_pkg::DATA_W'(r_cfg.min_drive);
            default:                prdata = '0;
        endcase
    end

endmodule

### hw/rtl/fps_ctrl.sv
// fps_ctrl: tick sequencer, servo state and shared multiplier; drives fps_div.
// Depends on fps_pkg.
module fps_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  fps_pkg::t_in      i_in,
    output logic              o_ready,
    input  fps_pkg::t_cfg     i_cfg,
    output fps_pkg::t_div_req o_div_req,
    input  fps_pkg::t_div_rsp i_div_rsp,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output fps_pkg::t_out     o_res
);

    typedef enum logic [3:0] {
        S_IDLE, S_NORM, S_ERR, S_RAW, S_ACC, S_D10S, S_D10W, S_MP,
        S_MD, S_MI, S_DHZS, S_DHZW, S_CLAMP, S_SCALE, S_DRIVE, S_FIN
    } t_state;

    localparam logic signed [fps_pkg::EI_W:0]   EI_HI  = (fps_pkg::EI_W + 1)'(fps_pkg::ILIM);
    localparam logic signed [fps_pkg::EI_W:0]   EI_LO  = -EI_HI;
    localparam logic signed [fps_pkg::SUM_W-1:0] SUM_HI = fps_pkg::SUM_W'(fps_pkg::OUT_LIM);
    localparam logic signed [fps_pkg::SUM_W-1:0] SUM_LO = -SUM_HI;

    t_state                              r_state;
    logic [fps_pkg::POS_W-1:0]           r_target;
    logic [fps_pkg::POS_W-1:0]           r_pos;
    logic [fps_pkg::POS_W-1:0]           r_prev;
    logic signed [fps_pkg::EI_W-1:0]     r_ei;
    logic signed [fps_pkg::FR_W-1:0]     r_fr;
    logic signed [fps_pkg::ERR_W-1:0]    r_err;
    logic signed [fps_pkg::ERR_W-1:0]    r_diff;
    logic signed [fps_pkg::PROD_W-1:0]   r_prod;
    logic signed [fps_pkg::ACC_W-1:0]    r_acc;
    logic                                r_neg;
    logic signed [fps_pkg::SUM_W-1:0]    r_sum;
    logic signed [fps_pkg::CL_W-1:0]     r_cl;
    logic signed [fps_pkg::SC_W-1:0]     r_sc;
    logic signed [fps_pkg::DRIVE_W-1:0]  r_drive;
    logic                                r_settled;
    fps_pkg::t_div_req                   r_div;

    // Normalization
    logic [fps_pkg::POS_W-1:0]           w_tgt;
    logic                                w_cal_ok;
    logic [fps_pkg::SAMPLE_W-1:0]        w_range;
    logic signed [fps_pkg::SAMPLE_W:0]   w_offs;
    // Error, integral
    logic signed [fps_pkg::ERR_W-1:0]    w_err;
    logic [fps_pkg::ERR_W-1:0]           w_mag;
    logic signed [fps_pkg::EI_W:0]       w_ei_sum;
    logic signed [fps_pkg::EI_W-1:0]     w_ei_cl;
    // Divider operands and results
    logic [fps_pkg::ACC_MAG_W-1:0]       w_acc_mag;
    logic [fps_pkg::IP_MAG_W-1:0]        w_ip_mag;
    logic signed [fps_pkg::FR_W-1:0]     w_q10;
    logic signed [fps_pkg::IT_W-1:0]     w_qit;
    // Shared multiplier
    logic [fps_pkg::GAIN_W-1:0]          w_mul_a;
    logic signed [fps_pkg::MB_W-1:0]     w_mul_b;
    logic signed [fps_pkg::PROD_W-1:0]   w_prod;
    // Output stage
    logic [fps_pkg::SC_W-1:0]            w_sc_mag;
    logic [fps_pkg::SC_W-1:0]            w_scq;
    logic [fps_pkg::DUTY_W-1:0]          w_dmag;
    logic [fps_pkg::DUTY_W-1:0]          w_dmin;
    logic signed [fps_pkg::DRIVE_W-1:0]  w_drive;
    logic signed [fps_pkg::DRIVE_W-1:0]  w_ndrive;

    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_FIN);
    assign o_div_req   = r_div;

    always_comb begin
        w_tgt    = (i_in.target_position > fps_pkg::POS_ONE) ? fps_pkg::POS_ONE
                                                             : i_in.target_position;
        w_cal_ok = (i_cfg.pot_max > i_cfg.pot_min);
        w_range  = i_cfg.pot_max - i_cfg.pot_min;
        w_offs   = $signed({1'b0, i_in.pot_sample}) - $signed({1'b0, i_cfg.pot_min});

        w_err    = $signed({1'b0, r_target}) - $signed({1'b0, r_pos});
        w_mag    = w_err[fps_pkg::ERR_W-1] ? fps_pkg::ERR_W'(-w_err) : fps_pkg::ERR_W'(w_err);
        w_ei_sum = (fps_pkg::EI_W + 1)'(r_ei) + (fps_pkg::EI_W + 1)'(w_err);
        if (w_ei_sum > EI_HI) begin
            w_ei_cl = fps_pkg::EI_W'(EI_HI);
        end else if (w_ei_sum < EI_LO) begin
            w_ei_cl = fps_pkg::EI_W'(EI_LO);
        end else begin
            w_ei_cl = fps_pkg::EI_W'(w_ei_sum);
        end

        // round half away from zero: (|x| + 5) / 10 with sign restored
        w_acc_mag = (r_acc[fps_pkg::ACC_W-1] ? fps_pkg::ACC_MAG_W'(-r_acc)
                                             : fps_pkg::ACC_MAG_W'(r_acc))
                    + fps_pkg::ACC_MAG_W'(5);
        w_ip_mag  = r_prod[fps_pkg::PROD_W-1] ? fps_pkg::IP_MAG_W'(-r_prod)
                                              : fps_pkg::IP_MAG_W'(r_prod);
        w_q10 = $signed({1'b0, i_div_rsp.quotient[fps_pkg::FR_W-2:0]});
        w_qit = $signed({1'b0, i_div_rsp.quotient[fps_pkg::IT_W-2:0]});

        unique case (r_state)
            S_RAW: begin
                w_mul_a = fps_pkg::GAIN_W'(fps_pkg::LOOP_RATE_HZ);
                w_mul_b = fps_pkg::MB_W'(r_diff);
            end
            S_MP: begin
                w_mul_a = i_cfg.gain_p;
                w_mul_b = fps_pkg::MB_W'(r_err);
            end
            S_MD: begin
                w_mul_a = i_cfg.gain_d;
                w_mul_b = fps_pkg::MB_W'(r_fr);
            end
            S_MI: begin
                w_mul_a = i_cfg.gain_i;
                w_mul_b = fps_pkg::MB_W'(r_ei);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
        w_prod = $signed({1'b0, w_mul_a}) * w_mul_b;

        // drive = trunc(sum * 255 / 2^19), clamped, raised to min drive
        w_sc_mag = r_sc[fps_pkg::SC_W-1] ? fps_pkg::SC_W'(-r_sc) : fps_pkg::SC_W'(r_sc);
        w_scq    = w_sc_mag >> fps_pkg::OUT_SHIFT;
        w_dmag   = (w_scq > fps_pkg::SC_W'(255)) ? 8'd255 : w_scq[fps_pkg::DUTY_W-1:0];
        w_dmin   = ((w_dmag != '0) && (w_dmag < i_cfg.min_drive)) ? i_cfg.min_drive : w_dmag;
        w_drive  = r_sc[fps_pkg::SC_W-1] ? -$signed({1'b0, w_dmin}) : $signed({1'b0, w_dmin});

        w_ndrive = -r_drive;
        o_res.drive     = r_drive;
        o_res.up_duty   = (r_drive > 0) ? r_drive[fps_pkg::DUTY_W-1:0] : '0;
        o_res.down_duty = (r_drive < 0) ? w_ndrive[fps_pkg::DUTY_W-1:0] : '0;
        o_res.position  = r_pos;
        o_res.settled   = r_settled;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pos     <= fps_pkg::POS_HALF;
            r_prev    <= '0;
            r_ei      <= '0;
            r_fr      <= '0;
            r_div     <= '0;
        end else begin
            r_div.start <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_target <= w_tgt;
                        if (!w_cal_ok) begin
                            r_state <= S_ERR;                 // keep last position
                        end else if (w_offs[fps_pkg::SAMPLE_W] || (w_offs == '0)) begin
                            r_pos   <= '0;
                            r_state <= S_ERR;
                        end else if (w_offs[fps_pkg::SAMPLE_W-1:0] >= w_range) begin
                            r_pos   <= fps_pkg::POS_ONE;
                            r_state <= S_ERR;
                        end else begin
                            r_div.start    <= 1'b1;
                            r_div.dividend <= fps_pkg::DIV_DW'({w_offs[fps_pkg::SAMPLE_W-1:0],
                                              15'd0}) << fps_pkg::NORM_SH;
                            r_div.divisor  <= fps_pkg::DVS_W'(w_range);
                            r_div.pairs    <= fps_pkg::PAIR_CW'(fps_pkg::NORM_PAIRS);
                            r_state        <= S_NORM;
                        end
                    end
                end
                S_NORM: begin
                    if (i_div_rsp.done) begin
                        r_pos   <= i_div_rsp.quotient[fps_pkg::POS_W-1:0];
                        r_state <= S_ERR;
                    end
                end
                S_ERR: begin
                    r_prev <= r_pos;
                    if (w_mag < fps_pkg::ERR_W'(i_cfg.deadband)) begin
                        r_settled <= 1'b1;
                        r_ei      <= '0;
                        r_fr      <= '0;
                        r_drive   <= '0;
                        r_state   <= S_FIN;
                    end else begin
                        r_settled <= 1'b0;
                        r_err     <= w_err;
                        r_ei      <= w_ei_cl;
                        r_diff    <= $signed({1'b0, r_pos}) - $signed({1'b0, r_prev});
                        r_state   <= S_RAW;
                    end
                end
                S_RAW: begin
                    r_prod  <= w_prod;                        // raw rate
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc   <= fps_pkg::ACC_W'(r_prod) + (fps_pkg::ACC_W'(r_fr) <<< 3)
                               + fps_pkg::ACC_W'(r_fr);
                    r_state <= S_D10S;
                end
                S_D10S: begin
                    r_neg          <= r_acc[fps_pkg::ACC_W-1];
                    r_div.start    <= 1'b1;
                    r_div.dividend <= fps_pkg::DIV_DW'(w_acc_mag) << fps_pkg::D10_SH;
                    r_div.divisor  <= fps_pkg::DVS_W'(10);
                    r_div.pairs    <= fps_pkg::PAIR_CW'(fps_pkg::D10_PAIRS);
                    r_state        <= S_D10W;
                end
                S_D10W: begin
                    if (i_div_rsp.done) begin
                        r_fr    <= r_neg ? -w_q10 : w_q10;
                        r_state <= S_MP;
                    end
                end
                S_MP: begin
                    r_prod  <= w_prod;                        // P term
                    r_state <= S_MD;
                end
                S_MD: begin
                    r_sum   <= fps_pkg::SUM_W'(r_prod);
                    r_prod  <= w_prod;                        // D term
                    r_state <= S_MI;
                end
                S_MI: begin
                    r_sum   <= r_sum - fps_pkg::SUM_W'(r_prod);
                    r_prod  <= w_prod;                        // gain_i * integral
                    r_state <= S_DHZS;
                end
                S_DHZS: begin
                    r_neg          <= r_prod[fps_pkg::PROD_W-1];
                    r_div.start    <= 1'b1;
                    r_div.dividend <= fps_pkg::DIV_DW'(w_ip_mag) << fps_pkg::DHZ_SH;
                    r_div.divisor  <= fps_pkg::DVS_W'(fps_pkg::LOOP_RATE_HZ);
                    r_div.pairs    <= fps_pkg::PAIR_CW'(fps_pkg::DHZ_PAIRS);
                    r_state        <= S_DHZW;
                end
                S_DHZW: begin
                    if (i_div_rsp.done) begin
                        r_sum   <= r_sum + fps_pkg::SUM_W'(r_neg ? -w_qit : w_qit);
                        r_state <= S_CLAMP;
                    end
                end
                S_CLAMP: begin
                    if (r_sum > SUM_HI) begin
                        r_cl <= fps_pkg::CL_W'(SUM_HI);
                    end else if (r_sum < SUM_LO) begin
                        r_cl <= fps_pkg::CL_W'(SUM_LO);
                    end else begin
                        r_cl <= fps_pkg::CL_W'(r_sum);
                    end
                    r_state <= S_SCALE;
                end
                S_SCALE: begin
                    r_sc    <= (fps_pkg::SC_W'(r_cl) <<< 8) - fps_pkg::SC_W'(r_cl);
                    r_state <= S_DRIVE;
                end
                S_DRIVE: begin
                    r_drive <= w_drive;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
